/* rtl/nqse_pkg.sv */
// nqse_pkg: shared types and constants for the n-quads string escaper
// holds the escaped-sequence struct and the character codes used by the encoder
// no dependencies
package nqse_pkg;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_A_OFS  = 8'h57;

	localparam logic [7:0] BYTE_TAB = 8'h09;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_CR  = 8'h0D;

	localparam logic [2:0] CNT_PLAIN = 3'd1;
	localparam logic [2:0] CNT_SHORT = 3'd2;
	localparam logic [2:0] CNT_HEX   = 3'd6;

	typedef struct packed {
		logic [2:0] count;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] b4;
		logic [7:0] b5;
	} esc_seq_t;

	// lowercase ascii hex digit of one nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] ext;
		ext = {4'h0, nib};
		if (nib < 4'd10) begin
			return CH_ZERO + ext;
		end else begin
			return CH_A_OFS + ext;
		end
	endfunction

endpackage

/* rtl/nqse_encode.sv */
// nqse_encode: maps one byte to its escaped sequence of one to six bytes
// combinational only
// depends on nqse_pkg
module nqse_encode (
	input  logic [7:0]         in_byte,
	output nqse_pkg::esc_seq_t seq
);

	always_comb begin
		seq = '0;
		case (in_byte) inside
			[8'h00:8'h08], 8'h0B, 8'h0C, [8'h0E:8'h1F], [8'h7F:8'hA0]: begin
				seq.count = nqse_pkg::CNT_HEX;
				seq.b0    = nqse_pkg::CH_BSLASH;
				seq.b1    = nqse_pkg::CH_U;
				seq.b2    = nqse_pkg::CH_ZERO;
				seq.b3    = nqse_pkg::CH_ZERO;
				seq.b4    = nqse_pkg::hex_digit(in_byte[7:4]);
				seq.b5    = nqse_pkg::hex_digit(in_byte[3:0]);
			end
			nqse_pkg::BYTE_TAB: begin
				seq.count = nqse_pkg::CNT_SHORT;
				seq.b0    = nqse_pkg::CH_BSLASH;
				seq.b1    = nqse_pkg::CH_T;
			end
			nqse_pkg::BYTE_LF: begin
				seq.count = nqse_pkg::CNT_SHORT;
				seq.b0    = nqse_pkg::CH_BSLASH;
				seq.b1    = nqse_pkg::CH_N;
			end
			nqse_pkg::BYTE_CR: begin
				seq.count = nqse_pkg::CNT_SHORT;
				seq.b0    = nqse_pkg::CH_BSLASH;
				seq.b1    = nqse_pkg::CH_R;
			end
			nqse_pkg::CH_QUOTE, nqse_pkg::CH_BSLASH: begin
				seq.count = nqse_pkg::CNT_SHORT;
				seq.b0    = nqse_pkg::CH_BSLASH;
				seq.b1    = in_byte;
			end
			default: begin
				seq.count = nqse_pkg::CNT_PLAIN;
				seq.b0    = in_byte;
			end
		endcase
	end

endmodule

/* rtl/nquads_string_escaper.sv */
// nquads_string_escaper: top level, input register, encoder, result register
// path: accepted byte -> input register (byte_s1) -> encoder -> result register (seq_s2)
// throughput: one byte per cycle, limited only by out_stall backpressure
// reset: arst_n clears both stage valids; payload registers are not reset
// depends on nqse_pkg and nqse_encode
module nquads_string_escaper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] out_count,
	output logic [7:0] out_b0,
	output logic [7:0] out_b1,
	output logic [7:0] out_b2,
	output logic [7:0] out_b3,
	output logic [7:0] out_b4,
	output logic [7:0] out_b5
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               valid_s2;
	nqse_pkg::esc_seq_t seq_s2;
	nqse_pkg::esc_seq_t seq_next;
	logic               adv_s2;
	logic               adv_s1;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	nqse_encode u_encode (
		.in_byte (byte_s1),
		.seq     (seq_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			byte_s1 <= in_byte;
		end
		if (adv_s2 && valid_s1) begin
			seq_s2 <= seq_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_count = seq_s2.count;
	assign out_b0    = seq_s2.b0;
	assign out_b1    = seq_s2.b1;
	assign out_b2    = seq_s2.b2;
	assign out_b3    = seq_s2.b3;
	assign out_b4    = seq_s2.b4;
	assign out_b5    = seq_s2.b5;

endmodule
